FILE: src/iol_pkg.sv
// iol_pkg: shared types and codes for the indexed ordered list.
// Request and status codes, and the control word that steers the cell row.
// No dependencies.
package iol_pkg;

    // Widest index the cell row ever compares (a count of up to 1024 entries).
    localparam int IDX_MAX_W = 11;

    typedef enum logic [2:0] {
        CMD_INSERT     = 3'd0,
        CMD_REMOVE_AT  = 3'd1,
        CMD_GET        = 3'd2,
        CMD_FIND       = 3'd3,
        CMD_REMOVE_ALL = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_INDEX = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE,
        CELL_DROP
    } t_cell_op;

    typedef struct packed {
        t_cell_op               op;
        logic [IDX_MAX_W-1:0]   pos;
        logic [IDX_MAX_W-1:0]   tail;
    } t_cell_ctl;

endpackage

FILE: src/iol_if.sv
// iol_if: valid/ready channel interfaces for the indexed ordered list.
// Request channel and response channel; no dependencies.
interface iol_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [5:0]  position;
    logic [31:0] value;

    modport source (output valid, output cmd, output position, output value, input ready);
    modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

interface iol_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] data_out;
    logic [4:0]  found_at;
    logic [5:0]  length;

    modport source (output valid, output status, output data_out, output found_at,
                    output length, input ready);
    modport sink   (input valid, input status, input data_out, input found_at,
                    input length, output ready);
endinterface

FILE: src/iol_cell.sv
// iol_cell: one storage cell of the list row.
// Holds one entry and loads from its neighbors as the control word says.
// Depends on iol_pkg.
module iol_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int IDX        = 0
) (
    input  logic                    i_clk,
    input  iol_pkg::t_cell_ctl      i_ctl,
    input  logic [DATA_WIDTH-1:0]   i_val,
    input  logic [DATA_WIDTH-1:0]   i_left,
    input  logic [DATA_WIDTH-1:0]   i_right,
    input  logic [DATA_WIDTH-1:0]   i_head,
    output logic [DATA_WIDTH-1:0]   o_data
);
    import iol_pkg::*;

    localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(IDX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (MY_IDX > i_ctl.pos) begin
                    n_data = i_left;
                end else if (MY_IDX == i_ctl.pos) begin
                    n_data = i_val;
                end
            end
            CELL_DELETE: begin
                if (MY_IDX >= i_ctl.pos) begin
                    n_data = i_right;
                end
            end
            CELL_ROTATE: begin
                // tail cell takes the head entry, cells below it move down
                if (MY_IDX == i_ctl.tail) begin
                    n_data = i_head;
                end else if (MY_IDX < i_ctl.tail) begin
                    n_data = i_right;
                end
            end
            CELL_DROP: n_data = i_right;
            default:   n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

FILE: src/indexed_ordered_list.sv
// indexed_ordered_list: top level of the bounded ordered list.
// Instantiates the iol_cell row; depends on iol_pkg and iol_if.
//
// A list of up to CAPACITY words held in a row of cells, one entry per cell,
// position 0 in cell 0. Insert and remove-at shift the whole row at once, and
// they, every rejected request and every request on an empty list give their
// result in the cycle after the request beat. Get, find and remove-all
// rotate the list once through the row, one entry per cycle past cell 0,
// which is the single compare/read point: their result is registered on
// the last rotation step. Remove-all drops matching entries as they
// pass cell 0, so the list comes back compacted and in order. One request is
// worked at a time; a new one is taken while the previous result is being
// handed off. Entries need no clearing after reset; only positions below the
// count are ever read.
module indexed_ordered_list #(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    iol_req_if.sink     i_req,
    iol_rsp_if.source   o_rsp
);
    import iol_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY + 1);
    localparam int CW    = (IDX_W > 6) ? IDX_W : 6;

    typedef enum logic {ST_IDLE, ST_SCAN} t_state;

    t_state                 r_state;
    logic [IDX_W-1:0]       r_count;
    logic [IDX_W-1:0]       r_step;
    logic [IDX_W-1:0]       r_len;
    logic [IDX_W-1:0]       r_pos;
    logic [IDX_W-1:0]       r_where;
    t_cmd                   r_cmd;
    logic [DATA_WIDTH-1:0]  r_val;
    logic [DATA_WIDTH-1:0]  r_data;
    logic                   r_hit;
    logic                   r_out_valid;
    logic                   n_out_valid;
    t_status                r_status;
    logic [31:0]            r_data_out;
    logic [4:0]             r_found_at;
    logic [5:0]             r_length;

    logic [DATA_WIDTH-1:0]  w_cell [CAPACITY];
    logic [DATA_WIDTH-1:0]  w_head;
    logic [63:0]            w_val_ext;
    logic [DATA_WIDTH-1:0]  w_req_val;
    t_cmd                   w_cmd;
    logic                   w_accept;
    logic [CW-1:0]          w_pos_c;
    logic [CW-1:0]          w_cnt_c;
    logic                   w_pos_lt;
    logic                   w_pos_le;
    logic                   w_full;
    logic                   w_ins_ok;
    logic                   w_rem_ok;
    logic                   w_scan_start;
    logic [IDX_W-1:0]       w_n_count;
    logic                   w_match;
    logic                   w_last;
    logic                   w_drop;
    logic                   w_get_hit;
    logic                   w_find_hit;
    logic [IDX_W-1:0]       w_find_idx;
    logic [IDX_W-1:0]       w_len_next;
    logic [DATA_WIDTH-1:0]  w_get_data;
    t_cell_ctl              w_ctl;

    function automatic logic [5:0] f_len(input logic [IDX_W-1:0] n);
        logic [31:0] t;
        t = 32'(n);
        return t[5:0];
    endfunction

    function automatic logic [4:0] f_idx(input logic [IDX_W-1:0] n);
        logic [31:0] t;
        t = 32'(n);
        return t[4:0];
    endfunction

    function automatic logic [31:0] f_word(input logic [DATA_WIDTH-1:0] d);
        logic [63:0] t;
        t = 64'(d);
        return t[31:0];
    endfunction

    // cell row
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cell[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cell[g+1];
        end
        iol_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX        (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_val   (w_req_val),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_head),
            .o_data  (w_cell[g])
        );
    end

    assign w_head    = w_cell[0];
    assign w_val_ext = 64'(i_req.value);
    assign w_req_val = w_val_ext[DATA_WIDTH-1:0];
    assign w_cmd     = t_cmd'(i_req.cmd);

    assign i_req.ready = (r_state == ST_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_pos_c  = CW'(i_req.position);
    assign w_cnt_c  = CW'(r_count);
    assign w_pos_lt = w_pos_c < w_cnt_c;
    assign w_pos_le = w_pos_c <= w_cnt_c;
    assign w_full   = r_count == IDX_W'(CAPACITY);

    assign w_ins_ok = w_accept && (w_cmd == CMD_INSERT) && w_pos_le && !w_full;
    assign w_rem_ok = w_accept && (w_cmd == CMD_REMOVE_AT) && w_pos_lt;
    assign w_scan_start = w_accept && (r_count != '0) &&
                          (((w_cmd == CMD_GET) && w_pos_lt) || (w_cmd == CMD_FIND) ||
                           (w_cmd == CMD_REMOVE_ALL));

    assign w_n_count = w_ins_ok ? r_count + IDX_W'(1) :
                       w_rem_ok ? r_count - IDX_W'(1) : r_count;

    // one rotation step per cycle while scanning
    assign w_match    = w_head == r_val;
    assign w_last     = r_step == (r_count - IDX_W'(1));
    assign w_drop     = (r_cmd == CMD_REMOVE_ALL) && w_match;
    assign w_get_hit  = r_step == r_pos;
    assign w_find_hit = r_hit || w_match;
    assign w_find_idx = r_hit ? r_where : r_step;
    assign w_len_next = w_drop ? r_len - IDX_W'(1) : r_len;
    assign w_get_data = w_get_hit ? w_head : r_data;

    // result beat: held while stalled, loaded by a direct result or the last scan step
    assign n_out_valid = (r_out_valid && !o_rsp.ready) || (w_accept && !w_scan_start) ||
                         ((r_state == ST_SCAN) && w_last);

    always_comb begin
        w_ctl.op   = CELL_HOLD;
        w_ctl.pos  = IDX_MAX_W'(w_pos_c);
        w_ctl.tail = IDX_MAX_W'(r_len - IDX_W'(1));
        if (r_state == ST_IDLE) begin
            if (w_ins_ok) begin
                w_ctl.op = CELL_INSERT;
            end else if (w_rem_ok) begin
                w_ctl.op = CELL_DELETE;
            end
        end else begin
            w_ctl.op = w_drop ? CELL_DROP : CELL_ROTATE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_cmd      <= w_cmd;
                        r_val      <= w_req_val;
                        r_pos      <= IDX_W'(w_pos_c);
                        r_step     <= '0;
                        r_len      <= r_count;
                        r_hit      <= 1'b0;
                        r_where    <= '0;
                        r_data     <= '0;
                        r_count    <= w_n_count;
                        r_data_out <= '0;
                        r_found_at <= '0;
                        r_length   <= f_len(w_n_count);
                        if (w_scan_start) begin
                            r_state <= ST_SCAN;
                        end else begin
                            case (w_cmd)
                                CMD_INSERT: begin
                                    if (!w_pos_le) begin
                                        r_status <= STATUS_BAD_INDEX;
                                    end else if (w_full) begin
                                        r_status <= STATUS_FULL;
                                    end else begin
                                        r_status <= STATUS_OK;
                                    end
                                end
                                CMD_REMOVE_AT: begin
                                    r_status <= w_pos_lt ? STATUS_OK : STATUS_BAD_INDEX;
                                end
                                CMD_GET:        r_status <= STATUS_BAD_INDEX;
                                CMD_FIND:       r_status <= STATUS_NOT_FOUND;
                                CMD_REMOVE_ALL: r_status <= STATUS_OK;
                                default:        r_status <= STATUS_OK;
                            endcase
                        end
                    end
                end
                ST_SCAN: begin
                    r_step <= r_step + IDX_W'(1);
                    r_len  <= w_len_next;
                    if ((r_cmd == CMD_GET) && w_get_hit) begin
                        r_data <= w_head;
                    end
                    if ((r_cmd == CMD_FIND) && w_match && !r_hit) begin
                        r_hit   <= 1'b1;
                        r_where <= r_step;
                    end
                    if (w_last) begin
                        r_state     <= ST_IDLE;
                        r_count     <= w_len_next;
                        r_length    <= f_len(w_len_next);
                        r_status    <= ((r_cmd == CMD_FIND) && !w_find_hit) ?
                                       STATUS_NOT_FOUND : STATUS_OK;
                        r_data_out  <= (r_cmd == CMD_GET) ? f_word(w_get_data) : '0;
                        r_found_at  <= ((r_cmd == CMD_FIND) && w_find_hit) ?
                                       f_idx(w_find_idx) : '0;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.status   = r_status;
    assign o_rsp.data_out = r_data_out;
    assign o_rsp.found_at = r_found_at;
    assign o_rsp.length   = r_length;

endmodule

FILE: src/iol_checker.sv
// iol_checker: port-level checks for indexed_ordered_list, attached by bind.
// Depends on iol_pkg and on the top level's channel ports.
module iol_checker #(
    parameter int CAPACITY = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_ready,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [1:0]  i_rsp_status,
    input  logic [31:0] i_rsp_data_out,
    input  logic [4:0]  i_rsp_found_at,
    input  logic [5:0]  i_rsp_length
);
    import iol_pkg::*;

    // stalled result beat holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status) &&
        $stable(i_rsp_data_out) && $stable(i_rsp_found_at) && $stable(i_rsp_length))
        else $error("response changed while stalled");

    // no new request while a result is stuck
    a_no_take_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |-> !i_req_ready)
        else $error("request taken while response stalled");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (32'(i_rsp_length) <= CAPACITY))
        else $error("length above capacity");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status == STATUS_FULL) |->
        (CAPACITY > 63) || (32'(i_rsp_length) == CAPACITY))
        else $error("full status with list not full");

    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status != STATUS_OK) |->
        (i_rsp_data_out == '0) && (i_rsp_found_at == '0))
        else $error("nonzero data on failed request");

endmodule

bind indexed_ordered_list iol_checker #(.CAPACITY(CAPACITY)) u_iol_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_rsp_status   (o_rsp.status),
    .i_rsp_data_out (o_rsp.data_out),
    .i_rsp_found_at (o_rsp.found_at),
    .i_rsp_length   (o_rsp.length)
);
